// ----- src/cda_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cda_pkg
// shared types, constants and the month length table for the calendar date
// adder
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned ADD_W   = 12;

  localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
  localparam logic [YEAR_W-1:0]  RST_YEAR   = 14'd2000;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST   = 5'd31;

  // year / 100 as (year * DIV100_MUL) >> DIV100_SHIFT, exact for year <= 9999
  localparam int unsigned        DIV100_SHIFT = 19;
  localparam logic [12:0]        DIV100_MUL   = 13'd5243;
  localparam int unsigned        PROD_W       = YEAR_W + 13;
  localparam int unsigned        REM_W        = 7;
  localparam logic [REM_W-1:0]   REM_TOP      = 7'd99;
  localparam logic [6:0]         HUNDRED      = 7'd100;

  localparam logic [REM_W-1:0]   RST_REM      = 7'd0;
  localparam logic [1:0]         RST_CENT     = 2'd0;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_ADD  = 1'b1
  } cda_op_t;

  typedef struct packed {
    logic               operation;
    logic [YEAR_W-1:0]  load_year;
    logic [MONTH_W-1:0] load_month;
    logic [DAY_W-1:0]   load_day;
    logic [ADD_W-1:0]   days_to_add;
  } cda_in_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic               year_overflow;
  } cda_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_MUL,
    S_LD_SPLIT,
    S_LD_CLAMP,
    S_ADD,
    S_DONE
  } cda_state_t;

  typedef struct packed {
    logic capture;
    logic ld_mul;
    logic ld_split;
    logic ld_clamp;
    logic add_step;
    logic publish;
  } cda_cmd_t;

  typedef struct packed {
    logic add_done;
  } cda_status_t;

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- src/calendar_date_adder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_adder
// Gregorian date register with load and add-days items
//
// in_valid/in_stall/in_word carry one item: a load sets year, month and day
// (out-of-range fields are clamped to a valid date), an add advances the date
// by days_to_add days. Every item gives one word on out_valid/out_stall/
// out_word holding the date after it and the year overflow flag.
// A load passes through the multiply, split and clamp steps before the result word.
// An add advances one month boundary per step until the remaining days fit in
// the current month, or the date saturates at 9999-12-31 with the overflow flag.
// One item is worked on at a time; in_stall is high until the result is
// placed in the output register. The next item is taken while that word
// still waits on out_stall; its own result holds until the word is taken.
// Reset sets the date to 2000-01-01 and leaves no word pending.
// ----------------------------------------------------------------------------
module calendar_date_adder (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire cda_pkg::cda_in_t in_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output cda_pkg::cda_out_t     out_word
);

  cda_pkg::cda_cmd_t    cmd;
  cda_pkg::cda_status_t status;

  cda_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_word.operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .cmd          (cmd)
  );

  cda_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .status   (status),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

// ----- src/cda_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cda_ctrl
// sequencer for load and add items, and the result word valid flag
// ----------------------------------------------------------------------------
module cda_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_operation,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire cda_pkg::cda_status_t status,
  output cda_pkg::cda_cmd_t         cmd
);

  cda_pkg::cda_state_t state_r;
  cda_pkg::cda_state_t state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                accept;
  logic                out_free;

  assign accept   = in_valid && (state_r == cda_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cda_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_operation == cda_pkg::OP_ADD) begin
            state_nxt = cda_pkg::S_ADD;
          end else begin
            state_nxt = cda_pkg::S_LD_MUL;
          end
        end
      end
      cda_pkg::S_LD_MUL:   state_nxt = cda_pkg::S_LD_SPLIT;
      cda_pkg::S_LD_SPLIT: state_nxt = cda_pkg::S_LD_CLAMP;
      cda_pkg::S_LD_CLAMP: state_nxt = cda_pkg::S_DONE;
      cda_pkg::S_ADD: begin
        if (status.add_done) begin
          state_nxt = cda_pkg::S_DONE;
        end
      end
      cda_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = cda_pkg::S_IDLE;
        end
      end
      default: state_nxt = cda_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_stall      = (state_r != cda_pkg::S_IDLE);
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      cda_pkg::S_IDLE:     cmd.capture  = accept;
      cda_pkg::S_LD_MUL:   cmd.ld_mul   = 1'b1;
      cda_pkg::S_LD_SPLIT: cmd.ld_split = 1'b1;
      cda_pkg::S_LD_CLAMP: cmd.ld_clamp = 1'b1;
      cda_pkg::S_ADD:      cmd.add_step = 1'b1;
      cda_pkg::S_DONE: begin
        if (out_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cda_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- src/cda_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cda_dpath
// date registers, leap tracking, one month advance per step, result word
// ----------------------------------------------------------------------------
module cda_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cda_pkg::cda_in_t  in_word,
  input  wire cda_pkg::cda_cmd_t cmd,
  output cda_pkg::cda_status_t   status,
  output cda_pkg::cda_out_t      out_word
);

  logic [cda_pkg::YEAR_W-1:0]  cur_year_r;
  logic [cda_pkg::MONTH_W-1:0] cur_month_r;
  logic [cda_pkg::DAY_W-1:0]   cur_day_r;
  logic [cda_pkg::REM_W-1:0]   rem_r;
  logic [1:0]                  cent_r;
  logic                        ovf_r;

  logic [cda_pkg::YEAR_W-1:0]  ld_year_r;
  logic [cda_pkg::MONTH_W-1:0] ld_month_r;
  logic [cda_pkg::DAY_W-1:0]   ld_day_r;
  logic [cda_pkg::ADD_W-1:0]   inc_r;
  logic [cda_pkg::PROD_W-1:0]  prod_r;
  cda_pkg::cda_out_t           out_word_r;

  logic                        leap;
  logic [cda_pkg::DAY_W-1:0]   len;
  logic [cda_pkg::ADD_W:0]     sum;
  logic                        fits;
  logic                        at_end;
  logic [cda_pkg::ADD_W-1:0]   used;
  logic [7:0]                  quot;
  logic [cda_pkg::YEAR_W-1:0]  quot_x100;
  logic [cda_pkg::YEAR_W-1:0]  rem_full;
  logic [cda_pkg::YEAR_W-1:0]  sat_year;
  logic [cda_pkg::MONTH_W-1:0] clamp_month;

  // leap: divisible by 4 and not by 100, or by 400
  assign leap = (cur_year_r[1:0] == 2'd0) && ((rem_r != '0) || (cent_r == 2'd0));
  assign len  = cda_pkg::days_in(cur_month_r, leap);

  assign sum    = {{(cda_pkg::ADD_W + 1 - cda_pkg::DAY_W){1'b0}}, cur_day_r}
                + {1'b0, inc_r};
  assign fits   = sum <= {{(cda_pkg::ADD_W + 1 - cda_pkg::DAY_W){1'b0}}, len};
  assign at_end = (cur_month_r == cda_pkg::MONTH_DEC) && (cur_year_r >= cda_pkg::MAX_YEAR);
  assign used   = {{(cda_pkg::ADD_W - cda_pkg::DAY_W){1'b0}},
                   5'(len - cur_day_r + cda_pkg::DAY_FIRST)};

  assign status.add_done = fits || at_end;

  assign quot      = prod_r[cda_pkg::PROD_W-1 -: 8];
  assign quot_x100 = cda_pkg::YEAR_W'(quot) * cda_pkg::YEAR_W'(cda_pkg::HUNDRED);
  assign rem_full  = ld_year_r - quot_x100;

  assign sat_year = (in_word.load_year > cda_pkg::MAX_YEAR) ? cda_pkg::MAX_YEAR
                                                             : in_word.load_year;
  always_comb begin
    priority if (in_word.load_month == '0) begin
      clamp_month = cda_pkg::MONTH_JAN;
    end else if (in_word.load_month > cda_pkg::MONTH_DEC) begin
      clamp_month = cda_pkg::MONTH_DEC;
    end else begin
      clamp_month = in_word.load_month;
    end
  end

  // item capture and load arithmetic
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ld_year_r  <= sat_year;
      ld_month_r <= clamp_month;
      ld_day_r   <= in_word.load_day;
      inc_r      <= in_word.days_to_add;
    end else if (cmd.add_step && !fits) begin
      inc_r <= inc_r - used;
    end
    if (cmd.ld_mul) begin
      prod_r <= cda_pkg::PROD_W'(ld_year_r) * cda_pkg::PROD_W'(cda_pkg::DIV100_MUL);
    end
  end

  // current date
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_year_r  <= cda_pkg::RST_YEAR;
      cur_month_r <= cda_pkg::MONTH_JAN;
      cur_day_r   <= cda_pkg::DAY_FIRST;
      rem_r       <= cda_pkg::RST_REM;
      cent_r      <= cda_pkg::RST_CENT;
      ovf_r       <= 1'b0;
    end else begin
      if (cmd.capture) begin
        ovf_r <= 1'b0;
      end
      if (cmd.ld_split) begin
        cur_year_r  <= ld_year_r;
        cur_month_r <= ld_month_r;
        rem_r       <= rem_full[cda_pkg::REM_W-1:0];
        cent_r      <= quot[1:0];
      end
      if (cmd.ld_clamp) begin
        priority if (ld_day_r == '0) begin
          cur_day_r <= cda_pkg::DAY_FIRST;
        end else if (ld_day_r > len) begin
          cur_day_r <= len;
        end else begin
          cur_day_r <= ld_day_r;
        end
      end
      if (cmd.add_step) begin
        priority if (fits) begin
          cur_day_r <= sum[cda_pkg::DAY_W-1:0];
        end else if (at_end) begin
          cur_year_r  <= cda_pkg::MAX_YEAR;
          cur_month_r <= cda_pkg::MONTH_DEC;
          cur_day_r   <= cda_pkg::DAY_LAST;
          ovf_r       <= 1'b1;
        end else if (cur_month_r == cda_pkg::MONTH_DEC) begin
          cur_day_r   <= cda_pkg::DAY_FIRST;
          cur_month_r <= cda_pkg::MONTH_JAN;
          cur_year_r  <= cur_year_r + 14'd1;
          if (rem_r == cda_pkg::REM_TOP) begin
            rem_r  <= '0;
            cent_r <= cent_r + 2'd1;
          end else begin
            rem_r <= rem_r + 7'd1;
          end
        end else begin
          cur_day_r   <= cda_pkg::DAY_FIRST;
          cur_month_r <= cur_month_r + 4'd1;
        end
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_word_r.out_year      <= cur_year_r;
      out_word_r.out_month     <= cur_month_r;
      out_word_r.out_day       <= cur_day_r;
      out_word_r.year_overflow <= ovf_r;
    end
  end

  assign out_word = out_word_r;

endmodule
`default_nettype wire
